// File: rtl/core/lcat_pkg.sv
package lcat_pkg;

  // Block length and the field widths that follow from the converter word.
  localparam int SAMPLES_PER_AVERAGE = 10;
  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 28;
  localparam int CNT_W    = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int SCALE_W  = 32;
  localparam int DBAND_W  = 32;
  localparam int SCALED_W = SAMPLE_W + SCALE_W;
  localparam int NET_W    = SCALED_W + 1;

  // Bit 23 flip turns a two's-complement word into offset binary.
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 24'h800000;

  // Division of the block sum by its length as a multiply by a rounded-up reciprocal.
  // With a shift of 35 the result is exact for every 28-bit sum and any length up to 16.
  localparam int DIV_SHIFT = 35;
  localparam int RECIP_W   = 36;
  localparam longint RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  // Reset values of the configuration registers.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16777216;
  localparam logic [DBAND_W-1:0] DBAND_RESET = 32'd8389;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 1'b1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes.
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TARE   = 1'b1
  } op_t;

  // One queued operation: a finished block sum or a tare.
  typedef struct packed {
    op_t              op;
    logic [SUM_W-1:0] sum;
  } q_entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: rtl/core/lcat_if.sv
// Input channel: one command and its converter word per request.
interface lcat_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [lcat_pkg::SAMPLE_W-1:0]     raw_sample;

  modport source (output valid, output cmd, output raw_sample, input ready);
  modport sink   (input valid, input cmd, input raw_sample, output ready);
endinterface

// Result channel: one averaged block per request.
interface lcat_out_if;
  logic                              valid;
  logic                              ready;
  logic [lcat_pkg::SAMPLE_W-1:0]     average_code;
  logic signed [lcat_pkg::NET_W-1:0] net_load;

  modport source (output valid, output average_code, output net_load, input ready);
  modport sink   (input valid, input average_code, input net_load, output ready);
endinterface

// File: rtl/core/lcat_front.sv
module lcat_front (
  input  logic                     clk,
  input  logic                     rst_n,
  lcat_in_if.sink                  in_ch,
  input  logic                     q_full,
  output lcat_pkg::q_push_t        push
);

  logic [lcat_pkg::SUM_W-1:0]    sum_r;
  logic [lcat_pkg::SUM_W-1:0]    sum_nxt;
  logic [lcat_pkg::CNT_W-1:0]    count_r;
  logic [lcat_pkg::CNT_W-1:0]    count_nxt;
  logic [lcat_pkg::SAMPLE_W-1:0] word_ob;
  logic [lcat_pkg::SUM_W-1:0]    sum_add;
  logic                          fire;
  logic                          last;
  lcat_pkg::op_t                 op;

  // A request is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign op          = lcat_pkg::op_t'(in_ch.cmd);

  // Offset-binary conversion and running sum.
  assign word_ob = in_ch.raw_sample ^ lcat_pkg::SIGN_FLIP;
  assign sum_add = sum_r + lcat_pkg::SUM_W'(word_ob);
  assign last    = (count_r == lcat_pkg::CNT_W'(lcat_pkg::SAMPLES_PER_AVERAGE - 1));

  // A tare always goes to the back; a sample only when it closes a block.
  always_comb begin
    push.valid     = fire && ((op == lcat_pkg::OP_TARE) || last);
    push.entry.op  = op;
    push.entry.sum = sum_add;
  end

  // Block accumulator.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (fire && (op == lcat_pkg::OP_SAMPLE)) begin
      if (last) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_r + lcat_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  // The sample count never reaches the block length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < lcat_pkg::CNT_W'(lcat_pkg::SAMPLES_PER_AVERAGE))
    else $error("sample count out of range");

endmodule

// File: rtl/core/lcat_queue.sv
module lcat_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lcat_pkg::q_push_t   push,
  input  logic                pop,
  output logic                full,
  output lcat_pkg::q_head_t   head
);

  lcat_pkg::q_entry_t          entries_r [lcat_pkg::QUEUE_DEPTH];
  logic [lcat_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [lcat_pkg::QPTR_W-1:0] wr_ptr_nxt;
  logic [lcat_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [lcat_pkg::QPTR_W-1:0] rd_ptr_nxt;
  logic [lcat_pkg::QCNT_W-1:0] cnt_r;
  logic [lcat_pkg::QCNT_W-1:0] cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (cnt_r == lcat_pkg::QCNT_W'(lcat_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = entries_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + lcat_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + lcat_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + lcat_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - lcat_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

  // The front never offers an operation while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && full))
    else $error("request pushed into a full queue");

  // The fill count rises by one on a push without a pop.
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + lcat_pkg::QCNT_W'(1)))
    else $error("queue fill count lost a push");

endmodule

// File: rtl/core/lcat_back.sv
module lcat_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lcat_pkg::q_head_t                 head,
  output logic                              pop,
  input  logic                              cfg_we,
  input  logic [lcat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcat_pkg::SCALE_W-1:0]      cfg_data,
  lcat_out_if.source                        out_ch
);

  logic                                   adv;
  logic [lcat_pkg::SUM_W+lcat_pkg::RECIP_W-1:0] quot_prod;

  logic [lcat_pkg::SCALE_W-1:0]           scale_r;
  logic [lcat_pkg::DBAND_W-1:0]           dband_r;
  logic [lcat_pkg::SCALED_W-1:0]          scaled_r;
  logic [lcat_pkg::SCALED_W-1:0]          tare_r;

  logic                                   s1_valid_r;
  lcat_pkg::op_t                          s1_op_r;
  logic [lcat_pkg::SAMPLE_W-1:0]          s1_mean_r;
  logic                                   s2_valid_r;
  lcat_pkg::op_t                          s2_op_r;
  logic [lcat_pkg::SAMPLE_W-1:0]          s2_mean_r;
  logic                                   s3_valid_r;
  lcat_pkg::op_t                          s3_op_r;
  logic [lcat_pkg::SAMPLE_W-1:0]          s3_mean_r;
  logic [lcat_pkg::NET_W-1:0]             s3_diff_r;
  logic [lcat_pkg::SCALED_W-1:0]          s3_mag_r;

  logic                                   out_valid_r;
  logic [lcat_pkg::SAMPLE_W-1:0]          out_mean_r;
  logic [lcat_pkg::NET_W-1:0]             out_net_r;

  logic [lcat_pkg::NET_W-1:0]             diff;
  logic [lcat_pkg::NET_W-1:0]             diff_neg;
  logic                                   in_band;

  // The whole pipe moves when the output register is free or being emptied.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head.valid;

  // Stage 1: mean by reciprocal multiply.
  assign quot_prod = head.entry.sum * lcat_pkg::RECIP;

  // Stage 3 arithmetic: signed difference and its magnitude.
  assign diff     = {1'b0, scaled_r} - {1'b0, tare_r};
  assign diff_neg = {1'b0, tare_r} - {1'b0, scaled_r};

  // Output stage: deadband is a strict test on the magnitude.
  assign in_band = (s3_mag_r < lcat_pkg::SCALED_W'(dband_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= head.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r && (s3_op_r == lcat_pkg::OP_SAMPLE);
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= head.entry.op;
      s1_mean_r  <= quot_prod[lcat_pkg::DIV_SHIFT +: lcat_pkg::SAMPLE_W];
      s2_op_r    <= s1_op_r;
      s2_mean_r  <= s1_mean_r;
      s3_op_r    <= s2_op_r;
      s3_mean_r  <= s2_mean_r;
      s3_diff_r  <= diff;
      s3_mag_r   <= diff[lcat_pkg::NET_W-1] ? diff_neg[lcat_pkg::SCALED_W-1:0]
                                             : diff[lcat_pkg::SCALED_W-1:0];
      out_mean_r <= s3_mean_r;
      out_net_r  <= in_band ? '0 : s3_diff_r;
    end
  end

  // Scaled and tare state change in request order as stage 1 retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_r <= '0;
      tare_r   <= '0;
    end else if (adv && s1_valid_r) begin
      if (s1_op_r == lcat_pkg::OP_TARE) begin
        tare_r <= scaled_r;
      end else begin
        scaled_r <= s1_mean_r * scale_r;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= lcat_pkg::SCALE_RESET;
      dband_r <= lcat_pkg::DBAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcat_pkg::REG_SCALE_FACTOR: scale_r <= cfg_data;
        lcat_pkg::REG_DEADBAND:     dband_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.average_code = out_mean_r;
  assign out_ch.net_load     = $signed(out_net_r);

  // A result appears only from a sample block leaving stage 3.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r && (s3_op_r == lcat_pkg::OP_SAMPLE)))
    else $error("result raised without a finished block");

  // A stalled pipe keeps the tare value unchanged.
  a_tare_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tare_r))
    else $error("tare changed during a stall");

endmodule

// File: rtl/core/load_cell_average_tare.sv
// Channel  Direction  Payload                          Handshake
// in_ch    input      cmd, raw_sample[23:0]            valid / ready
// out_ch   output     average_code[23:0], net_load[56:0] signed  valid / ready
// cfg_*    input      cfg_index[0], cfg_data[31:0]     cfg_we, no back-pressure
//
// One request is taken every cycle while the four-entry queue has room.
// A finished block goes from the queue through stages 1, 2, 3 and the output
// register to out_ch; the reciprocal and the scale multiply each own one stage.
// Reset is synchronous: sums, tare, scaled value and queue are cleared.
// A stalled out_ch freezes the back pipe; the front keeps filling the queue.
module load_cell_average_tare (
  input  logic                             clk,
  input  logic                             rst_n,
  lcat_in_if.sink                          in_ch,
  lcat_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lcat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcat_pkg::SCALE_W-1:0]     cfg_data
);

  lcat_pkg::q_push_t push;
  lcat_pkg::q_head_t head;
  logic              q_full;
  logic              pop;

  // Front: accumulate samples, forward block sums and tares.
  lcat_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // Queue between front and back.
  lcat_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Back: mean, scaling, tare and deadband.
  lcat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule

// File: tb/sv/load_cell_average_tare_tb.sv
`timescale 1ns / 1ps

module load_cell_average_tare_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 400;

  // One expected block: the mean code and the net load it should carry.
  typedef struct {
    logic [lcat_pkg::SAMPLE_W-1:0]     average_code;
    logic signed [lcat_pkg::NET_W-1:0] net_load;
  } block_result_t;

  // Scoreboard: tracks the averaging and tare state and checks each result in order.
  class load_cell_scoreboard;
    logic [lcat_pkg::SCALE_W-1:0]  scale_factor;
    logic [lcat_pkg::DBAND_W-1:0]  deadband;
    logic [lcat_pkg::SUM_W-1:0]    block_sum;
    logic [lcat_pkg::CNT_W-1:0]    block_count;
    logic [lcat_pkg::SCALED_W-1:0] scaled_load;
    logic [lcat_pkg::SCALED_W-1:0] tare_load;
    block_result_t                 expected_blocks[$];
    int                            failures;

    function new();
      scale_factor = lcat_pkg::SCALE_RESET;
      deadband     = lcat_pkg::DBAND_RESET;
      block_sum    = '0;
      block_count  = '0;
      scaled_load  = '0;
      tare_load    = '0;
      failures     = 0;
    endfunction

    function void write_register(logic [lcat_pkg::CFG_IDX_W-1:0] idx,
                                 logic [lcat_pkg::SCALE_W-1:0] value);
      if (idx == lcat_pkg::REG_SCALE_FACTOR) begin
        scale_factor = value;
      end else if (idx == lcat_pkg::REG_DEADBAND) begin
        deadband = value;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= 10) begin
        $display("%0t: mismatch: %s", $realtime, what);
      end
    endfunction

    // An accepted request: a tare latches the last scaled value, a sample adds to the block.
    function void note_request(lcat_pkg::op_t op, logic [lcat_pkg::SAMPLE_W-1:0] raw);
      logic [lcat_pkg::SUM_W-1:0]    quotient;
      logic [lcat_pkg::SAMPLE_W-1:0] mean;
      logic [lcat_pkg::SCALED_W-1:0] magnitude;
      logic                          below_tare;
      block_result_t                 blk;
      if (op == lcat_pkg::OP_TARE) begin
        tare_load = scaled_load;
        return;
      end
      block_sum   = block_sum + lcat_pkg::SUM_W'(raw ^ lcat_pkg::SIGN_FLIP);
      block_count = block_count + 1'b1;
      if (block_count < lcat_pkg::CNT_W'(lcat_pkg::SAMPLES_PER_AVERAGE)) begin
        return;
      end
      quotient    = block_sum / lcat_pkg::SUM_W'(lcat_pkg::SAMPLES_PER_AVERAGE);
      mean        = quotient[lcat_pkg::SAMPLE_W-1:0];
      block_sum   = '0;
      block_count = '0;
      scaled_load = lcat_pkg::SCALED_W'(mean) * lcat_pkg::SCALED_W'(scale_factor);
      below_tare  = scaled_load < tare_load;
      magnitude   = below_tare ? (tare_load - scaled_load) : (scaled_load - tare_load);
      blk.average_code = mean;
      // The deadband test is strict: a magnitude equal to it is reported.
      if (magnitude < lcat_pkg::SCALED_W'(deadband)) begin
        blk.net_load = '0;
      end else if (below_tare) begin
        blk.net_load = -$signed({1'b0, magnitude});
      end else begin
        blk.net_load = $signed({1'b0, magnitude});
      end
      expected_blocks.push_back(blk);
    endfunction

    // A result from the block is compared with the oldest expected block.
    function void check_result(logic [lcat_pkg::SAMPLE_W-1:0] avg,
                               logic signed [lcat_pkg::NET_W-1:0] net);
      block_result_t blk;
      if (expected_blocks.size() == 0) begin
        note_failure($sformatf("result with no block outstanding: average_code %0h net_load %0d",
                               avg, net));
        return;
      end
      blk = expected_blocks.pop_front();
      if (avg !== blk.average_code) begin
        note_failure($sformatf("average_code expected %0h actual %0h", blk.average_code, avg));
      end
      if (net !== blk.net_load) begin
        note_failure($sformatf("net_load expected %0d actual %0d", blk.net_load, net));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [lcat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lcat_pkg::SCALE_W-1:0]   cfg_data;

  lcat_in_if  in_if ();
  lcat_out_if out_if ();

  load_cell_average_tare dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  load_cell_scoreboard board = new();

  bit tx_idle;
  bit rx_idle;
  bit long_hold_req;
  int rx_hold;
  int quiet_cycles;

  always #6 clk = ~clk;

  // Result side: check accepted results and pace ready with idle bursts and long hold-offs.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      board.check_result(out_if.average_code, out_if.net_load);
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      rx_hold = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any accepted request or result ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, after an optional idle burst, and wait until it is taken.
  task automatic send_request(input lcat_pkg::op_t op,
                              input logic [lcat_pkg::SAMPLE_W-1:0] raw);
    int gap;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= op;
    in_if.raw_sample <= raw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_request(op, raw);
  endtask

  // Stop offering, wait for every outstanding block, then let any queued tare settle.
  task automatic drain_blocks();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles; the block is idle here.
  task automatic program_config(input logic [lcat_pkg::SCALE_W-1:0] scale,
                                input logic [lcat_pkg::DBAND_W-1:0] dband);
    cfg_we    <= 1'b1;
    cfg_index <= lcat_pkg::REG_SCALE_FACTOR;
    cfg_data  <= scale;
    @(posedge clk);
    board.write_register(lcat_pkg::REG_SCALE_FACTOR, scale);
    cfg_index <= lcat_pkg::REG_DEADBAND;
    cfg_data  <= dband;
    @(posedge clk);
    board.write_register(lcat_pkg::REG_DEADBAND, dband);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: whole blocks of one shape with tares mixed in at random.
  // Flat blocks sit one code either side of a base, so tared loads land on small steps.
  task automatic run_traffic(input int items, input bit flat_bias);
    int                            k;
    int                            style;
    logic [lcat_pkg::SAMPLE_W-1:0] base;
    logic [lcat_pkg::SAMPLE_W-1:0] level;
    logic [lcat_pkg::SAMPLE_W-1:0] raw;
    base  = lcat_pkg::SAMPLE_W'($urandom_range(16, 24'hFFFFF0));
    style = 1;
    level = base;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(lcat_pkg::OP_TARE, lcat_pkg::SAMPLE_W'($urandom));
      end else begin
        if (board.block_count == 0) begin
          if (flat_bias) begin
            style = ($urandom_range(0, 3) == 0) ? 1 : 0;
          end else begin
            style = $urandom_range(0, 3);
          end
          if (style == 0) begin
            level = base + lcat_pkg::SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
          end else begin
            level = $urandom_range(0, 1) ? '1 : '0;
          end
        end
        case (style)
          0, 2: raw = level ^ lcat_pkg::SIGN_FLIP;
          1: raw = lcat_pkg::SAMPLE_W'($urandom);
          default: begin
            case ($urandom_range(0, 3))
              0: raw = 24'h800000;
              1: raw = 24'h7FFFFF;
              2: raw = 24'h000000;
              default: raw = 24'hFFFFFF;
            endcase
          end
        endcase
        send_request(lcat_pkg::OP_SAMPLE, raw);
      end
    end
  endtask

  initial begin
    int k;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = lcat_pkg::REG_SCALE_FACTOR;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.cmd        = lcat_pkg::OP_SAMPLE;
    in_if.raw_sample = '0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    long_hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: a tare before any block has finished,
    // then a block of mixed extremes with a tare inside it, then a block at full scale.
    send_request(lcat_pkg::OP_TARE, 24'hFFFFFF);
    send_request(lcat_pkg::OP_SAMPLE, 24'h800000);
    send_request(lcat_pkg::OP_SAMPLE, 24'h7FFFFF);
    send_request(lcat_pkg::OP_SAMPLE, 24'h000000);
    send_request(lcat_pkg::OP_SAMPLE, 24'hFFFFFF);
    send_request(lcat_pkg::OP_TARE, 24'h123456);
    send_request(lcat_pkg::OP_SAMPLE, 24'h800000);
    send_request(lcat_pkg::OP_SAMPLE, 24'h7FFFFF);
    send_request(lcat_pkg::OP_SAMPLE, 24'h000001);
    send_request(lcat_pkg::OP_SAMPLE, 24'h800001);
    send_request(lcat_pkg::OP_SAMPLE, 24'h7FFFFE);
    send_request(lcat_pkg::OP_SAMPLE, 24'h400000);
    for (k = 0; k < lcat_pkg::SAMPLES_PER_AVERAGE; k++) begin
      send_request(lcat_pkg::OP_SAMPLE, 24'h7FFFFF);
    end
    send_request(lcat_pkg::OP_TARE, 24'h000000);
    drain_blocks();

    // Extreme settings, then mixed random ones.
    program_config(32'hFFFFFFFF, 32'h0);
    run_traffic(65, 1'b0);
    drain_blocks();

    program_config(32'h0, 32'hFFFFFFFF);
    run_traffic(65, 1'b0);
    drain_blocks();

    // Unit scale with a deadband of exactly one code, so flat blocks hit the boundary.
    program_config(32'h01000000, 32'h01000000);
    run_traffic(65, 1'b1);
    drain_blocks();

    program_config(lcat_pkg::SCALE_W'($urandom_range(1, 1024)),
                   lcat_pkg::DBAND_W'($urandom));
    run_traffic(65, 1'b0);
    drain_blocks();

    program_config(lcat_pkg::SCALE_W'($urandom), lcat_pkg::DBAND_W'($urandom));
    run_traffic(65, 1'b0);
    drain_blocks();

    // Back-pressure: the result side holds off while requests keep coming, then the
    // sender pauses mid-phase until every block has been delivered.
    program_config(lcat_pkg::SCALE_RESET, lcat_pkg::DBAND_RESET);
    long_hold_req = 1'b1;
    tx_idle = 1'b0;
    run_traffic(100, 1'b0);
    tx_idle = 1'b1;
    drain_blocks();
    run_traffic(20, 1'b1);
    drain_blocks();

    // Final stretch at full rate on both sides.
    program_config(lcat_pkg::SCALE_W'($urandom_range(1, 1 << 20)),
                   lcat_pkg::DBAND_W'($urandom_range(0, 1 << 30)));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_traffic(65, 1'b1);
    drain_blocks();

    if (board.failures == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lcat_pkg.sv
rtl/core/lcat_if.sv
rtl/core/lcat_front.sv
rtl/core/lcat_queue.sv
rtl/core/lcat_back.sv
rtl/core/load_cell_average_tare.sv
tb/sv/load_cell_average_tare_tb.sv
